// ===== rtl/core/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// shared constants, types and fixed-point helpers of the tridiagonal solver
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_PIV = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // request and answer of the shared divider
  // numerator carries one extra bit so that the negated most negative word fits
  typedef struct packed {
    logic              start;
    logic signed [WORD_W:0]   num;
    logic signed [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              zero;
    logic signed [WORD_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[WORD_W-1:0];
    return r;
  endfunction

  // round to nearest, ties away from zero, of a full product
  function automatic logic signed [WORD_W-1:0] round_prod(
    input logic signed [63:0] prod, input int frac);
    logic [63:0] m;
    logic signed [65:0] s;
    m = prod[63] ? 64'(-prod) : 64'(prod);
    m = (m + (64'd1 << (frac - 1))) >> frac;
    s = prod[63] ? -$signed({2'b00, m}) : $signed({2'b00, m});
    return sat32(s);
  endfunction

endpackage

// ===== rtl/core/tts_ram.sv =====
// ----------------------------------------------------------------------------
// tts_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/tts_div.sv =====
// ----------------------------------------------------------------------------
// tts_div
// restoring fixed-point divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tts_div #(
  parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tts_pkg::div_req_t req,
  output tts_pkg::div_rsp_t rsp
);
  import tts_pkg::*;

  // quotient of (2n<<f + d) / 2d: numerator up to 32+f+2 bits
  localparam int NW = WORD_W + FRAC_BITS + 2;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]     nreg;
  logic [NW-1:0]     qreg;
  logic [WORD_W+1:0] dreg;
  logic [WORD_W+2:0] rem;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              neg;
  logic [WORD_W+2:0] trial;
  logic [63:0]       qclip;
  logic signed [65:0] qs;

  always_comb begin
    trial = {rem[WORD_W+1:0], nreg[NW-1]} - {1'b0, dreg};
    qclip = (qreg > NW'(64'h1_0000_0000)) ? 64'h1_0000_0000 : 64'(qreg);
    qs    = neg ? -$signed({2'b00, qclip}) : $signed({2'b00, qclip});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      dreg <= '0;
      rsp  <= '0;
    end else if (req.start) begin
      if (req.den == 0) begin
        rsp.done <= 1'b1;
        rsp.zero <= 1'b1;
        rsp.quo  <= '0;
      end else begin
        logic [WORD_W:0] nm, dm;
        nm = req.num[WORD_W] ? -req.num : req.num;
        dm = req.den[WORD_W-1] ? -{1'b1, req.den} : {1'b0, req.den};
        rsp.done <= 1'b0;
        neg  <= req.num[WORD_W] ^ req.den[WORD_W-1];
        nreg <= (NW'({nm, 1'b0}) << FRAC_BITS) + NW'(dm);
        dreg <= {dm, 1'b0};
        rem  <= '0;
        qreg <= '0;
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end
    end else if (busy) begin
      rsp.done <= 1'b0;
      if (!trial[WORD_W+2]) begin
        rem  <= trial;
        qreg <= {qreg[NW-2:0], 1'b1};
      end else begin
        rem  <= {rem[WORD_W+1:0], nreg[NW-1]};
        qreg <= {qreg[NW-2:0], 1'b0};
      end
      nreg <= {nreg[NW-2:0], 1'b0};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end else if (cnt == '0 && qreg != '1 && rsp.done == 1'b0 && dreg != '0) begin
      rsp.done <= 1'b1;
      rsp.zero <= 1'b0;
      rsp.quo  <= sat32(qs);
      dreg     <= '0;
    end else begin
      rsp.done <= 1'b0;
    end
  end
endmodule

// ===== rtl/core/tridiagonal_thomas_solver_unit.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver_unit
// thomas-algorithm solver for tridiagonal systems, q16.16 saturating
// ----------------------------------------------------------------------------
// Rows enter one per transfer on s_axis; each row costs one multiply stage
// and one or two passes through the shared bit-serial divider of
// 32+FRAC_BITS+2 steps, so a row that is not last holds off the input until
// both its quotients are back and the last row offers its root once its one
// division is done. The sweep coefficients live in two single-port rams.
// After the row flagged by tlast the block back-substitutes and emits the
// roots on m_axis from the last row down to row 0, each root after the first
// taking a ram read, a multiply and an add once the one before is taken. No
// further row is taken until the last root has left.
module tridiagonal_thomas_solver_unit #(
  parameter int MAX_ROWS  = tts_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sub_diag[31:0], main_diag[63:32], super_diag[95:64], rhs[127:96]
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // last_row
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // root[31:0], row_index[37:32], status[39:38], not_dominant[40], zero pad
  output logic [47:0]  m_axis_tdata,
  output logic         m_axis_tlast    // last_out
);
  import tts_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = AW + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_DIVP = 8'b0000_0100,
    S_DIVQ = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_BMUL = 8'b0010_0000,
    S_OUT  = 8'b0100_0000,
    S_WAIT = 8'b1000_0000
  } state_t;

  state_t state;

  logic signed [WORD_W-1:0] a, b, c, d, den, num, prev_p, prev_q, x, pmul;
  logic signed [WORD_W-1:0] mp, mq;
  logic        last, first, dom_fail, not_dom;
  logic [1:0]  err;
  logic [CW-1:0] row_count, row;
  logic                     div_start;
  logic signed [WORD_W:0]   div_num;
  logic signed [WORD_W-1:0] div_den;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [WORD_W-1:0] p_rd, q_rd;

  tts_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS)) u_p (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(prev_p), .rdata(p_rd));
  tts_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS)) u_q (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(drsp.quo), .rdata(q_rd));

  tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign dreq = '{start: div_start, num: div_num, den: div_den};

  assign s_axis_tready = (state == S_IDLE);
  // coefficient write when q of a non-last row arrives; else read address
  assign ram_we   = (state == S_DIVQ) && drsp.done && !last;
  assign ram_addr = ram_we ? row_count[AW-1:0] : row[AW-1:0];

  function automatic logic [WORD_W:0] mag(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? -{1'b1, v} : {1'b0, v};
  endfunction

  // divider start pulse: p (or the root) after the multiply, q after p
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_MUL) || (state == S_DIVP && drsp.done);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; prev_p <= '0; prev_q <= '0; row_count <= '0;
      dom_fail <= 1'b0; err <= ST_OK; m_axis_tvalid <= 1'b0;
      div_num <= '0; div_den <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          if (!s_axis_tlast && row_count >= CW'(MAX_ROWS - 1)) begin
            err <= ST_OVERFLOW;
          end else begin
            logic signed [WORD_W-1:0] ta, tc;
            ta = (row_count == '0) ? '0 : s_axis_tdata[31:0];
            tc = s_axis_tlast ? '0 : s_axis_tdata[95:64];
            a <= ta; b <= s_axis_tdata[63:32]; c <= tc; d <= s_axis_tdata[127:96];
            last <= s_axis_tlast; first <= (row_count == '0);
            if ({1'b0, mag(s_axis_tdata[63:32])} < {1'b0, mag(ta)} + {1'b0, mag(tc)})
              dom_fail <= 1'b1;
            mp <= round_prod(64'(ta) * 64'(prev_p), FRAC_BITS);
            mq <= round_prod(64'(ta) * 64'(prev_q), FRAC_BITS);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          logic signed [WORD_W-1:0] tden, tnum;
          tden = first ? b : sat32(66'(b) + 66'(mp));
          tnum = first ? d : sat32(66'(d) - 66'(mq));
          den <= tden; num <= tnum;
          div_den <= tden;
          // -c is taken unsaturated
          div_num <= last ? 33'(tnum) : -33'(c);
          state <= last ? S_DIVQ : S_DIVP;
        end
        S_DIVP: if (drsp.done) begin
          prev_p <= drsp.quo;
          if (drsp.zero && err == ST_OK) err <= ST_ZERO_PIV;
          div_num <= 33'(num); div_den <= den;
          state <= S_DIVQ;
        end
        S_DIVQ: if (drsp.done) begin
          if (drsp.zero && err == ST_OK) err <= ST_ZERO_PIV;
          if (!last) begin
            prev_q <= drsp.quo; row_count <= row_count + 1'b1; state <= S_IDLE;
          end else begin
            x <= drsp.quo; row <= row_count; not_dom <= dom_fail;
            m_axis_tvalid <= 1'b1; state <= S_OUT;
          end
        end
        S_OUT: if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
          if (row == '0) begin
            prev_p <= '0; prev_q <= '0; row_count <= '0;
            dom_fail <= 1'b0; err <= ST_OK; state <= S_IDLE;
          end else begin
            row <= row - 1'b1; state <= S_RD;
          end
        end
        S_RD: state <= S_WAIT;   // ram read in flight
        S_WAIT: begin
          pmul <= round_prod(64'($signed(p_rd)) * 64'(x), FRAC_BITS);
          prev_q <= q_rd;
          state <= S_BMUL;
        end
        S_BMUL: begin
          x <= sat32(66'(pmul) + 66'(prev_q));
          m_axis_tvalid <= 1'b1; state <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, not_dom, err, row[5:0], x};
  assign m_axis_tlast = (row == '0);

  // never offer a root while accepting rows
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready)) else $error("row taken during output");
  // row counter never passes the last storable row
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    row_count <= CW'(MAX_ROWS - 1)) else $error("row count overflow");
  // after the final root the system state is cleared
  a_clr: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_axis_tready && row == '0) |=> (row_count == '0 && err == ST_OK))
    else $error("state not cleared");
endmodule
